FILE: rtl/pwk_pkg.sv
// Shared types, constants and helper functions of the page-table walker.
// No dependencies; every other file of the walker imports this package.
`default_nettype none

package pwk_pkg;

    // Field widths of the words moved on the channels
    localparam int FUNC_W        = 2;
    localparam int WORD_INDEX_W  = 12;
    localparam int WORD_W        = 64;
    localparam int VADDR_W       = 48;
    localparam int PHYS_W        = 60;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 3;

    // Table geometry
    localparam int DEFAULT_TABLE_PAGES = 8;
    localparam int MAX_PAGE_W          = 6;
    localparam int ENTRY_IDX_W         = 9;
    localparam int ENTRIES_PER_TABLE   = 512;
    localparam int OFFSET_W            = 12;
    localparam int FRAME_LSB           = 12;
    localparam int FRAME_MSB           = 59;
    localparam int FRAME_W             = FRAME_MSB - FRAME_LSB + 1;
    localparam int FRAME_BYTES         = FRAME_W / 8;
    localparam int REM_W               = MAX_PAGE_W + 1;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;

    // Function codes of an input word
    localparam logic [FUNC_W-1:0] FUNC_WRITE     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNMAP     = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_ROOT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPAWNING_ROOT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_USE_SPAWNING  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED      = 2'd3;

    // Table levels, top level first
    localparam logic [1:0] LEVEL_4 = 2'd3;
    localparam logic [1:0] LEVEL_3 = 2'd2;
    localparam logic [1:0] LEVEL_2 = 2'd1;
    localparam logic [1:0] LEVEL_1 = 2'd0;

    // Command kinds after classification
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_TRANSLATE,
        KIND_UNMAP
    } t_kind;

    // One classified command as it travels from front to back
    typedef struct packed {
        t_kind                    kind;
        logic [WORD_INDEX_W-1:0]  word_index;
        logic [WORD_W-1:0]        word_value;
        logic [VADDR_W-1:0]       virt_addr;
        logic [MAX_PAGE_W-1:0]    root_page;
    } t_cmd;

    // Fold one byte into a running remainder modulo pages (rem < pages <= 64)
    function automatic logic [REM_W-1:0] mod_step(
        input logic [REM_W-1:0] rem,
        input logic [7:0]       digit,
        input int unsigned      pages
    );
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] p;
        r = rem;
        p = REM_W'(pages);
        for (int i = 7; i >= 0; i--) begin
            t = {r[REM_W-2:0], digit[i]};
            r = (t >= p) ? (t - p) : t;
        end
        return r;
    endfunction

    // Entry index of a virtual address at one table level
    function automatic logic [ENTRY_IDX_W-1:0] level_index(
        input logic [VADDR_W-1:0] va,
        input logic [1:0]         lvl
    );
        logic [ENTRY_IDX_W-1:0] idx;
        unique case (lvl)
            LEVEL_4: idx = va[47:39];
            LEVEL_3: idx = va[38:30];
            LEVEL_2: idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pwk_ifs.sv
// Channel interfaces of the page-table walker: input, result and configuration.
// Depends on pwk_pkg for field widths.
`default_nettype none

interface pwk_in_if import pwk_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [WORD_INDEX_W-1:0]  word_index;
    logic [WORD_W-1:0]        word_value;
    logic [VADDR_W-1:0]       virt_addr;

    modport source (output valid, func, word_index, word_value, virt_addr, input ready);
    modport sink   (input valid, func, word_index, word_value, virt_addr, output ready);
endinterface

interface pwk_out_if import pwk_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PHYS_W-1:0]  phys_addr;

    modport source (output valid, phys_addr, input ready);
    modport sink   (input valid, phys_addr, output ready);
endinterface

interface pwk_cfg_if import pwk_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pwk_front.sv
// Front end of the walker: root registers, input classification, root selection.
// Depends on pwk_pkg and the channel interfaces in pwk_ifs.
`default_nettype none

module pwk_front import pwk_pkg::*; #(
    parameter int unsigned TABLE_PAGES = DEFAULT_TABLE_PAGES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pwk_in_if.sink     i_in,
    pwk_cfg_if.sink    i_cfg,
    output t_cmd       o_push_data,
    output logic       o_push_valid,
    input  wire logic  i_push_ready
);

    localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;

    logic [CFG_DATA_W-1:0] r_cur_root;
    logic [CFG_DATA_W-1:0] r_spawn_root;
    logic                  r_use_spawn;
    logic [CFG_DATA_W-1:0] sel_root;
    logic [REM_W-1:0]      root_rem;
    logic                  write_in_range;
    t_kind                 kind;

    // Take configuration words at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_root   <= '0;
            r_spawn_root <= '0;
            r_use_spawn  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CURRENT_ROOT:  r_cur_root   <= i_cfg.data;
                CFG_SPAWNING_ROOT: r_spawn_root <= i_cfg.data;
                CFG_USE_SPAWNING:  r_use_spawn  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Pick the root table and wrap it into the store
    assign sel_root = r_use_spawn ? r_spawn_root : r_cur_root;
    assign root_rem = mod_step('0, 8'(sel_root), TABLE_PAGES);

    // Drop table writes that land beyond the store
    assign write_in_range = (32'(i_in.word_index) < 32'(STORE_WORDS));

    always_comb begin
        unique case (i_in.func)
            FUNC_WRITE:     kind = write_in_range ? KIND_WRITE : KIND_NONE;
            FUNC_TRANSLATE: kind = KIND_TRANSLATE;
            FUNC_UNMAP:     kind = KIND_UNMAP;
            default:        kind = KIND_NONE;
        endcase
    end

    // Hand the classified word to the queue
    assign o_push_valid           = i_in.valid;
    assign i_in.ready             = i_push_ready;
    assign o_push_data.kind       = kind;
    assign o_push_data.word_index = i_in.word_index;
    assign o_push_data.word_value = i_in.word_value;
    assign o_push_data.virt_addr  = i_in.virt_addr;
    assign o_push_data.root_page  = MAX_PAGE_W'(root_rem);

endmodule

`default_nettype wire

FILE: rtl/pwk_queue.sv
// Short command queue between the walker front and back.
// Depends on pwk_pkg for the command type and depth.
`default_nettype none

module pwk_queue import pwk_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_cmd  i_push_data,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_cmd       o_pop_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pwk_back.sv
// Back end of the walker: table store, level sequencer and result register.
// Depends on pwk_pkg and the result interface in pwk_ifs.
`default_nettype none

module pwk_back import pwk_pkg::*; #(
    parameter int unsigned TABLE_PAGES = DEFAULT_TABLE_PAGES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_pop_valid,
    output logic       o_pop_ready,
    input  wire t_cmd  i_pop_data,
    pwk_out_if.source  o_out
);

    localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int          AW          = $clog2(STORE_WORDS);
    localparam int          PW          = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam logic [PW-1:0] PAGE_MASK = PW'(TABLE_PAGES - 1);
    localparam bit          IS_POW2     = ((TABLE_PAGES & (TABLE_PAGES - 1)) == 0);
    localparam int          CNT_W       = $clog2(FRAME_BYTES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_REDUCE
    } t_state;

    // Table store
    logic [WORD_W-1:0] r_mem [STORE_WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;

    // Sequencer
    t_state             r_state,     n_state;
    t_cmd               r_cmd,       n_cmd;
    logic [1:0]         r_level,     n_level;
    logic [FRAME_W-1:0] r_frame,     n_frame;
    logic [REM_W-1:0]   r_rem,       n_rem;
    logic [CNT_W-1:0]   r_byte_cnt,  n_byte_cnt;
    logic               r_out_valid, n_out_valid;
    logic [PHYS_W-1:0]  r_out_phys,  n_out_phys;

    logic                   out_free;
    logic                   pop_fire;
    logic [REM_W-1:0]       rem_next;
    logic [PW-1:0]          data_page;
    logic [PW-1:0]          walk_page;
    logic [ENTRY_IDX_W-1:0] next_idx;
    logic [AW-1:0]          walk_addr;
    logic                   advance;

    // Read one word, write one word per cycle; read data registered
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign o_pop_ready = (r_state == ST_IDLE) && out_free;
    assign pop_fire    = o_pop_ready && i_pop_valid;

    assign o_out.valid     = r_out_valid;
    assign o_out.phys_addr = r_out_phys;

    // Next table page: low frame bits, or a byte-wise remainder
    assign rem_next  = mod_step(r_rem, r_frame[FRAME_W-1 -: 8], TABLE_PAGES);
    assign data_page = r_rd_data[FRAME_LSB +: PW] & PAGE_MASK;
    assign walk_page = (r_state == ST_REDUCE) ? PW'(rem_next) : data_page;
    assign next_idx  = level_index(r_cmd.virt_addr, r_level - 2'd1);
    assign walk_addr = AW'({walk_page, next_idx});

    assign advance = ((r_state == ST_WAIT) && (r_level != LEVEL_1) && IS_POW2) ||
                     ((r_state == ST_REDUCE) && (r_byte_cnt == CNT_W'(FRAME_BYTES - 1)));

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_level     = r_level;
        n_frame     = r_frame;
        n_rem       = r_rem;
        n_byte_cnt  = r_byte_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_phys  = r_out_phys;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (pop_fire) begin
                    n_cmd = i_pop_data;
                    unique case (i_pop_data.kind)
                        KIND_WRITE: begin
                            wr_en       = 1'b1;
                            wr_addr     = AW'(i_pop_data.word_index);
                            wr_data     = i_pop_data.word_value;
                            n_out_valid = 1'b1;
                            n_out_phys  = '0;
                        end
                        KIND_TRANSLATE, KIND_UNMAP: begin
                            rd_en   = 1'b1;
                            rd_addr = AW'({i_pop_data.root_page[PW-1:0],
                                           level_index(i_pop_data.virt_addr, LEVEL_4)});
                            n_level = LEVEL_4;
                            n_state = ST_WAIT;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_phys  = '0;
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if (r_level == LEVEL_1) begin
                    // Leaf entry in hand: frame plus page offset
                    n_out_valid = 1'b1;
                    n_out_phys  = {r_rd_data[FRAME_MSB:FRAME_LSB],
                                   r_cmd.virt_addr[OFFSET_W-1:0]};
                    n_state     = ST_IDLE;
                end else if (!IS_POW2) begin
                    n_frame    = r_rd_data[FRAME_MSB:FRAME_LSB];
                    n_rem      = '0;
                    n_byte_cnt = '0;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                n_rem      = rem_next;
                n_frame    = r_frame << 8;
                n_byte_cnt = r_byte_cnt + 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase

        // Step to the next level, or clear the leaf of an unmap
        if (advance) begin
            if ((r_level == LEVEL_2) && (r_cmd.kind == KIND_UNMAP)) begin
                wr_en       = 1'b1;
                wr_addr     = walk_addr;
                wr_data     = '0;
                n_out_valid = 1'b1;
                n_out_phys  = '0;
                n_state     = ST_IDLE;
            end else begin
                rd_en   = 1'b1;
                rd_addr = walk_addr;
                n_level = r_level - 2'd1;
                n_state = ST_WAIT;
            end
        end
    end

    // Hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_level    <= n_level;
        r_frame    <= n_frame;
        r_rem      <= n_rem;
        r_byte_cnt <= n_byte_cnt;
        r_out_phys <= n_out_phys;
    end

    // The store port never reads and writes in the same cycle
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("table store read and write in one cycle");

    // A new command is only taken while the result register can take its word
    a_pop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_fire |-> out_free)
        else $error("command taken with result register busy");

    // Only an unmap writes the store during a walk
    a_walk_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && (r_state != ST_IDLE)) |-> (r_cmd.kind == KIND_UNMAP))
        else $error("store written during a walk that is not an unmap");

    // Only a translation reads its leaf entry
    a_leaf_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_WAIT) && (r_level == LEVEL_1)) |-> (r_cmd.kind == KIND_TRANSLATE))
        else $error("leaf entry read by a command that is not a translation");

    // A walk never finishes with a result already waiting
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (n_state == ST_IDLE)) |-> !r_out_valid)
        else $error("walk finished over a waiting result");

endmodule

`default_nettype wire

FILE: rtl/four_level_page_table_walker_core.sv
// Four-level page-table walker over an on-chip store of TABLE_PAGES tables of
// 512 64-bit entries. One result word per input word: a table write goes to the
// store in the back end; a translation issues four dependent store reads, and,
// when TABLE_PAGES is not a power of two, each intermediate frame number is
// reduced modulo TABLE_PAGES a byte per cycle; an unmap issues three reads and
// ends with a write of zero to the leaf entry. A front end and a two-word queue
// accept new words while a walk runs and while a result waits, until the queue
// is full. Root pages are to be configured by the user only while idle; the
// block itself does not enforce this; store entries must be written before
// they are read, and the store has no clearing pass after reset.
`default_nettype none

module four_level_page_table_walker_core import pwk_pkg::*; #(
    parameter int unsigned TABLE_PAGES = DEFAULT_TABLE_PAGES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pwk_in_if.sink     i_in,
    pwk_cfg_if.sink    i_cfg,
    pwk_out_if.source  o_out
);

    t_cmd push_data;
    logic push_valid;
    logic push_ready;
    t_cmd pop_data;
    logic pop_valid;
    logic pop_ready;

    // Classify input words and hold the root registers
    pwk_front #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_data  (push_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready)
    );

    // Decouple the front from the walk
    pwk_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Walk the tables and deliver results
    pwk_back #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
